// File: hw/rtl/hbks_pkg.sv
// Shared types, constants and state codes for the hash-banked key set.
// No dependencies; every other file of the block but hbks_ram imports this package.
package hbks_pkg;

    // Default geometry of the slot store.
    localparam int HBKS_BANK_COUNT     = 4;
    localparam int HBKS_SLOTS_PER_BANK = 256;

    // Field widths.
    localparam int HASH_W     = 64;
    localparam int MAG_W      = 63;
    localparam int LEN_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int BANK_OUT_W = 2;

    // Hash step h*31 + (byte - 31), with the multiply done as (h << 5) - h.
    localparam int                HASH_SHIFT  = 5;
    localparam logic [HASH_W-1:0] BYTE_OFFSET = 64'd31;
    localparam logic [LEN_W-1:0]  LEN_MAX     = '1;

    // The bank remainder is formed one hex digit per cycle, top digit first.
    localparam int MOD_DIGIT_W = 4;
    localparam int MOD_STEPS   = HASH_W / MOD_DIGIT_W;
    localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

    // Key commands.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] key_byte;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        logic [MAG_W-1:0]      key_hash;
        logic [BANK_OUT_W-1:0] bank_index;
        logic                  present;
        logic                  newly_stored;
        logic                  bank_full;
    } t_out_item;

    typedef struct packed {
        logic [LEN_W-1:0] key_len;
        logic [MAG_W-1:0] hash;
    } t_slot_entry;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAG,
        ST_MOD,
        ST_FILL_RD,
        ST_FILL_WAIT,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } t_ctrl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic in_ready;
        logic start_key;
        logic mod_step;
        logic fill_rd;
        logic fill_latch;
        logic scan_step;
        logic set_present;
        logic set_full;
        logic write_slot;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic last_accept;
        logic mod_last;
        logic mag_zero;
        logic is_lookup;
        logic hit;
        logic miss;
        logic bank_room;
        logic out_free;
    } t_dp_status;

endpackage

// File: hw/rtl/hash_banked_key_set.sv
// Top level of the hash-banked key set: controller, datapath and checks.
// Depends on hbks_pkg, hbks_ctrl, hbks_datapath (and through it hbks_ram).

// Keys arrive one byte per transfer, first byte first, with the last byte
// marked; the command given with the last byte selects insert or lookup.
// Other bytes yield no result. A last byte yields exactly one result, after
// the magnitude, the bank remainder (one hex digit per cycle), the fetch of
// the bank's fill count, a scan of the N occupied slots of the hashed bank
// (at most SLOTS_PER_BANK, one per cycle through the slot memory read port),
// the write of a new slot on an insert that misses in a bank with room, and
// the load of the output register. A result is loaded only once the output
// register is empty or its result is taken. A key whose hash is zero skips
// the scan. Input transfers are held off while a key end is being processed;
// bytes of the next key are taken while an earlier result still waits on the
// output. After reset the block empties every bank before it takes the first
// byte. The hash is the magnitude of the 64-bit wrapping sum h*31 + (byte -
// 31), with the most negative value saturated.
module hash_banked_key_set
    import hbks_pkg::*;
#(
    parameter int BANK_COUNT     = HBKS_BANK_COUNT,
    parameter int SLOTS_PER_BANK = HBKS_SLOTS_PER_BANK
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    hbks_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    hbks_datapath #(
        .BANK_COUNT     (BANK_COUNT),
        .SLOTS_PER_BANK (SLOTS_PER_BANK)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // Input transfers are taken only while the controller waits for bytes.
    assign o_in_stall = !dp_cmd.in_ready;

    // A new slot is written only when the bank still has room.
    a_write_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.write_slot |-> dp_status.bank_room)
        else $error("slot written into a full bank");

    // At most one of present, newly stored and bank full is reported.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones({o_out_data.present, o_out_data.newly_stored,
                                    o_out_data.bank_full}) <= 1)
        else $error("conflicting result flags");

    // A zero hash is never found and never stored.
    a_zero_hash_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.key_hash == '0)) |->
            (!o_out_data.present && !o_out_data.newly_stored && !o_out_data.bank_full))
        else $error("zero hash reported as stored or present");

    // A result appears only after the controller loads the output register.
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(dp_cmd.load_out))
        else $error("result valid without a load");

endmodule

// File: hw/rtl/hbks_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module hbks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// File: hw/rtl/hbks_ctrl.sv
// Controller state machine for the hash-banked key set.
// Depends on hbks_pkg for the state enum and the command and status structs.
module hbks_ctrl
    import hbks_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    // State register; reset starts the sweep that empties every bank.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_status.last_accept) n_state = ST_MAG;
            end
            ST_MAG: begin
                n_state = ST_MOD;
            end
            ST_MOD: begin
                if (i_status.mod_last) n_state = ST_FILL_RD;
            end
            ST_FILL_RD: begin
                n_state = ST_FILL_WAIT;
            end
            ST_FILL_WAIT: begin
                n_state = i_status.mag_zero ? ST_DONE : ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.hit) begin
                    n_state = ST_DONE;
                end else if (i_status.miss) begin
                    if (i_status.is_lookup || !i_status.bank_room) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd             = '0;
        o_cmd.clear_step  = (r_state == ST_CLEAR);
        o_cmd.in_ready    = (r_state == ST_IDLE);
        o_cmd.start_key   = (r_state == ST_MAG);
        o_cmd.mod_step    = (r_state == ST_MOD);
        o_cmd.fill_rd     = (r_state == ST_FILL_RD);
        o_cmd.fill_latch  = (r_state == ST_FILL_WAIT);
        o_cmd.scan_step   = (r_state == ST_SCAN);
        o_cmd.set_present = (r_state == ST_SCAN) && i_status.hit;
        o_cmd.set_full    = (r_state == ST_SCAN) && !i_status.hit && i_status.miss
                            && !i_status.is_lookup && !i_status.bank_room;
        o_cmd.write_slot  = (r_state == ST_WRITE);
        o_cmd.load_out    = (r_state == ST_DONE) && i_status.out_free;
    end

endmodule

// File: hw/rtl/hbks_datapath.sv
// Datapath of the hash-banked key set: hash folding, magnitude, bank remainder,
// per-bank fill counts, slot store scan and the output register.
// Depends on hbks_pkg and hbks_ram.
module hbks_datapath
    import hbks_pkg::*;
#(
    parameter int BANK_COUNT     = HBKS_BANK_COUNT,
    parameter int SLOTS_PER_BANK = HBKS_SLOTS_PER_BANK
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    input  logic       i_in_valid,
    input  t_in_item   i_in_data,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output t_out_item  o_out_data
);

    localparam int BW    = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
    localparam int CW    = $clog2(SLOTS_PER_BANK + 1);
    localparam int TOTAL = BANK_COUNT * SLOTS_PER_BANK;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int MW    = BW + MOD_DIGIT_W;
    localparam int SW    = $bits(t_slot_entry);

    logic [HASH_W-1:0]    r_acc;
    logic [LEN_W-1:0]     r_len_cnt;
    logic [MAG_W-1:0]     r_mag;
    logic [LEN_W-1:0]     r_key_len;
    logic                 r_cmd;
    logic [HASH_W-1:0]    r_mod_sh;
    logic [MOD_CNT_W-1:0] r_mod_cnt;
    logic [BW-1:0]        r_rem;
    logic [BW-1:0]        r_clr_idx;
    logic [AW-1:0]        r_base;
    logic [CW-1:0]        r_fill;
    logic [CW-1:0]        r_issue_idx;
    logic                 r_pend;
    logic                 r_present;
    logic                 r_stored;
    logic                 r_full;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic                 byte_fire;
    logic [HASH_W-1:0]    n_acc;
    logic [HASH_W-1:0]    acc_neg;
    logic [MAG_W-1:0]     mag_abs;
    logic [MW-1:0]        n_rem;
    logic                 slot_issue;
    logic                 hit;
    logic                 miss;
    logic                 out_free;
    logic [BW+BANK_OUT_W-1:0] bank_ext;
    logic [CW-1:0]        fill_rd_data;
    logic                 fill_wr_en;
    logic [BW-1:0]        fill_wr_addr;
    logic [CW-1:0]        fill_wr_data;
    logic [AW-1:0]        slot_rd_addr;
    logic [AW-1:0]        slot_wr_addr;
    t_slot_entry          slot_wr_data;
    t_slot_entry          slot_rd_data;

    assign byte_fire = i_cmd.in_ready && i_in_valid;

    // One hash step per byte: h*31 + byte - 31, wrapping at 64 bits.
    assign n_acc = (r_acc << HASH_SHIFT) - r_acc
                   + {{(HASH_W-BYTE_W){1'b0}}, i_in_data.key_byte} - BYTE_OFFSET;

    // Magnitude of the two's complement hash; the most negative value saturates.
    assign acc_neg = ~r_acc + {{(HASH_W-1){1'b0}}, 1'b1};
    always_comb begin
        if (!r_acc[HASH_W-1]) begin
            mag_abs = r_acc[MAG_W-1:0];
        end else if (r_acc[MAG_W-1:0] == '0) begin
            mag_abs = '1;
        end else begin
            mag_abs = acc_neg[MAG_W-1:0];
        end
    end

    // Hash accumulator and saturating key length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_len_cnt <= '0;
        end else if (i_cmd.start_key) begin
            r_acc     <= '0;
            r_len_cnt <= '0;
        end else if (byte_fire) begin
            r_acc     <= n_acc;
            r_len_cnt <= (r_len_cnt == LEN_MAX) ? r_len_cnt : r_len_cnt + 1'b1;
        end
    end

    // Key end: capture the command, then the magnitude and length.
    always_ff @(posedge i_clk) begin
        if (byte_fire && i_in_data.last_byte) begin
            r_cmd <= i_in_data.command;
        end
        if (i_cmd.start_key) begin
            r_mag     <= mag_abs;
            r_key_len <= r_len_cnt;
        end
    end

    // Remainder step: fold in one digit and reduce below the bank count.
    always_comb begin
        n_rem = {r_rem, r_mod_sh[HASH_W-1 -: MOD_DIGIT_W]};
        for (int k = MOD_DIGIT_W - 1; k >= 0; k--) begin
            if (n_rem >= (MW'(BANK_COUNT) << k)) begin
                n_rem = n_rem - (MW'(BANK_COUNT) << k);
            end
        end
    end

    // Digit-serial remainder unit; r_rem ends as the bank number.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_key) begin
            r_mod_sh  <= {1'b0, mag_abs};
            r_mod_cnt <= '0;
            r_rem     <= '0;
        end else if (i_cmd.mod_step) begin
            r_mod_sh  <= r_mod_sh << MOD_DIGIT_W;
            r_mod_cnt <= r_mod_cnt + 1'b1;
            r_rem     <= n_rem[BW-1:0];
        end
    end

    // Sweep that empties every bank after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // Bank base address and fill count of the chosen bank.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_rd) begin
            r_base <= AW'(r_rem) * AW'(SLOTS_PER_BANK);
        end
        if (i_cmd.fill_latch) begin
            r_fill <= fill_rd_data;
        end
    end

    // Scan: one slot read issued per cycle, compared the cycle after.
    assign slot_issue = i_cmd.scan_step && (r_issue_idx != r_fill);
    assign hit        = r_pend && (slot_rd_data.hash == r_mag);
    assign miss       = !hit && !r_pend && (r_issue_idx == r_fill);

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_latch) begin
            r_issue_idx <= '0;
            r_pend      <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_pend <= slot_issue;
            if (slot_issue) begin
                r_issue_idx <= r_issue_idx + 1'b1;
            end
        end
    end

    // Result flags of the current key.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_key) begin
            r_present <= 1'b0;
            r_stored  <= 1'b0;
            r_full    <= 1'b0;
        end else begin
            if (i_cmd.set_present) r_present <= 1'b1;
            if (i_cmd.set_full)    r_full    <= 1'b1;
            if (i_cmd.write_slot)  r_stored  <= 1'b1;
        end
    end

    // Fill-count memory: cleared by the reset sweep, bumped on a new slot.
    assign fill_wr_en   = i_cmd.clear_step || i_cmd.write_slot;
    assign fill_wr_addr = i_cmd.clear_step ? r_clr_idx : r_rem;
    assign fill_wr_data = i_cmd.clear_step ? '0 : r_fill + 1'b1;

    hbks_ram #(
        .WIDTH (CW),
        .DEPTH (BANK_COUNT)
    ) u_fill_ram (
        .i_clk     (i_clk),
        .i_wr_en   (fill_wr_en),
        .i_wr_addr (fill_wr_addr),
        .i_wr_data (fill_wr_data),
        .i_rd_en   (i_cmd.fill_rd),
        .i_rd_addr (r_rem),
        .o_rd_data (fill_rd_data)
    );

    // Slot store: banks are filled in order, so slots at or past the fill
    // count are empty and never read.
    assign slot_rd_addr         = r_base + AW'(r_issue_idx);
    assign slot_wr_addr         = r_base + AW'(r_fill);
    assign slot_wr_data.key_len = r_key_len;
    assign slot_wr_data.hash    = r_mag;

    hbks_ram #(
        .WIDTH (SW),
        .DEPTH (TOTAL)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.write_slot),
        .i_wr_addr (slot_wr_addr),
        .i_wr_data (slot_wr_data),
        .i_rd_en   (slot_issue),
        .i_rd_addr (slot_rd_addr),
        .o_rd_data (slot_rd_data)
    );

    // Output register; a new result loads once the previous one is taken.
    assign out_free = !r_out_valid || !i_out_stall;
    assign bank_ext = {{BANK_OUT_W{1'b0}}, r_rem};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.key_hash     <= r_mag;
            r_out.bank_index   <= bank_ext[BANK_OUT_W-1:0];
            r_out.present      <= r_present;
            r_out.newly_stored <= r_stored;
            r_out.bank_full    <= r_full;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Status to the controller.
    always_comb begin
        o_status             = '0;
        o_status.clear_last  = (r_clr_idx == BW'(BANK_COUNT - 1));
        o_status.last_accept = byte_fire && i_in_data.last_byte;
        o_status.mod_last    = (r_mod_cnt == MOD_CNT_W'(MOD_STEPS - 1));
        o_status.mag_zero    = (r_mag == '0);
        o_status.is_lookup   = (r_cmd == CMD_LOOKUP);
        o_status.hit         = hit;
        o_status.miss        = miss;
        o_status.bank_room   = (r_fill != CW'(SLOTS_PER_BANK));
        o_status.out_free    = out_free;
    end

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for hash_banked_key_set: random idling on both sides,
// with a scoreboard that keeps its own copy of the banked slot store.
// Depends on hbks_pkg and the hash_banked_key_set RTL.
module tb_top;
    import hbks_pkg::*;

    localparam logic [HASH_W-1:0] HASH_MULT = 64'd31;
    localparam int TOTAL_ITEMS   = 1550;
    localparam int CYCLE_LIMIT   = 3_000_000;
    // Worst key end: magnitude, remainder, fill fetch, full scan, write, output.
    localparam int SETTLE_CYCLES = 300;
    localparam int MAX_PRINTS    = 40;
    localparam int FULL_BANK     = 1;

    // One pending input transfer; hold makes the sender wait for all results first.
    typedef struct {
        t_in_item item;
        bit       hold;
    } t_feed;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    t_feed       byte_q[$];
    t_out_item   answer_q[$];
    logic [127:0] known_key[$];
    int          known_len[$];

    // Scoreboard copy of the block state.
    logic [HASH_W-1:0] acc_hash;
    logic [LEN_W-1:0]  len_count;
    logic [MAG_W-1:0]  slot_hash [HBKS_BANK_COUNT][HBKS_SLOTS_PER_BANK];
    logic [LEN_W-1:0]  slot_len  [HBKS_BANK_COUNT][HBKS_SLOTS_PER_BANK];

    int errors        = 0;
    int sent_items    = 0;
    int results_seen  = 0;
    int cycle_count   = 0;

    hash_banked_key_set #(
        .BANK_COUNT    (HBKS_BANK_COUNT),
        .SLOTS_PER_BANK(HBKS_SLOTS_PER_BANK)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One polynomial hash step, wrapping at 64 bits.
    function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] h,
                                                    input logic [BYTE_W-1:0] b);
        return h * HASH_MULT + {{(HASH_W-BYTE_W){1'b0}}, b} - BYTE_OFFSET;
    endfunction

    // Two's complement magnitude, with the most negative value saturated.
    function automatic logic [MAG_W-1:0] hash_magnitude(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] neg;
        neg = ~h + 1'b1;
        if (!h[HASH_W-1]) return h[MAG_W-1:0];
        // Only the most negative value is still negative after negation.
        if (neg[HASH_W-1]) return '1;
        return neg[MAG_W-1:0];
    endfunction

    // Builds a key whose hash equals v exactly: base-31 digits offset by 31.
    function automatic int base31_key(input logic [HASH_W-1:0] v, output logic [127:0] k);
        logic [HASH_W-1:0] rest;
        logic [BYTE_W-1:0] digit [16];
        int n;
        rest = v;
        n = 0;
        k = '0;
        while (rest != 0) begin
            digit[n] = BYTE_W'(rest % HASH_MULT) + BYTE_W'(BYTE_OFFSET);
            rest = rest / HASH_MULT;
            n++;
        end
        for (int i = 0; i < n; i++) k[8*i +: 8] = digit[n-1-i];
        return n;
    endfunction

    // Folds one accepted byte into the scoreboard; a last byte resolves the key.
    task automatic track_key_byte(input t_in_item it);
        logic [MAG_W-1:0] mag;
        int bank;
        t_out_item ans;
        acc_hash = fold_byte(acc_hash, it.key_byte);
        if (len_count != LEN_MAX) len_count++;
        if (it.last_byte) begin
            mag  = hash_magnitude(acc_hash);
            bank = int'(mag % MAG_W'(HBKS_BANK_COUNT));
            ans = '0;
            ans.key_hash   = mag;
            ans.bank_index = BANK_OUT_W'(bank);
            // A zero hash means an empty slot, so it is never stored or found.
            if (mag != '0) begin
                if (it.command == CMD_INSERT) begin
                    ans.bank_full = 1'b1;
                    for (int s = 0; s < HBKS_SLOTS_PER_BANK; s++) begin
                        if (slot_hash[bank][s] == mag) begin
                            ans.present   = 1'b1;
                            ans.bank_full = 1'b0;
                            break;
                        end
                        if (slot_hash[bank][s] == '0) begin
                            slot_hash[bank][s] = mag;
                            slot_len[bank][s]  = len_count;
                            ans.newly_stored   = 1'b1;
                            ans.bank_full      = 1'b0;
                            break;
                        end
                    end
                end else begin
                    for (int s = 0; s < HBKS_SLOTS_PER_BANK; s++) begin
                        if (slot_hash[bank][s] == '0) break;
                        if (slot_hash[bank][s] == mag) begin
                            ans.present = 1'b1;
                            break;
                        end
                    end
                end
            end
            answer_q.push_back(ans);
            acc_hash  = '0;
            len_count = '0;
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (errors < MAX_PRINTS)
            $display("mismatch on %s at result %0d: got %h, want %h",
                     what, results_seen, got, want);
        errors++;
    endtask

    // Queues the bytes of one key; only the last byte's command counts.
    task automatic push_key(input logic [127:0] k, input int n, input logic cmd,
                            input bit hold);
        t_feed f;
        for (int i = 0; i < n; i++) begin
            f.item.command   = (i == n - 1) ? cmd : logic'($urandom_range(0, 1));
            f.item.key_byte  = k[8*i +: 8];
            f.item.last_byte = (i == n - 1);
            f.hold           = hold && (i == 0);
            byte_q.push_back(f);
        end
    endtask

    task automatic resend_known(input logic cmd, input bit hold);
        int idx;
        idx = $urandom_range(0, known_key.size() - 1);
        push_key(known_key[idx], known_len[idx], cmd, hold);
    endtask

    // Mix of repeated keys, zero-hash keys and fresh random keys.
    task automatic mixed_keys(input int upto, input bit hold_first);
        logic [127:0] k;
        int n;
        int pick;
        bit hold;
        hold = hold_first;
        while (byte_q.size() < upto) begin
            pick = $urandom_range(0, 99);
            if (pick < 35 && known_key.size() != 0) begin
                resend_known($urandom_range(0, 1) ? CMD_LOOKUP : CMD_INSERT, hold);
            end else if (pick < 40) begin
                k = '0;
                case ($urandom_range(0, 2))
                    0: begin k[7:0] = 8'd31; n = 1; end
                    1: begin k[7:0] = 8'd32; k[15:8] = 8'd0; n = 2; end
                    default: begin k[7:0] = 8'd31; k[15:8] = 8'd31; n = 2; end
                endcase
                push_key(k, n, $urandom_range(0, 1) ? CMD_LOOKUP : CMD_INSERT, hold);
            end else begin
                k = {$urandom, $urandom, $urandom, $urandom};
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
                push_key(k, n, ($urandom_range(0, 99) < 60) ? CMD_INSERT : CMD_LOOKUP, hold);
                known_key.push_back(k);
                known_len.push_back(n);
            end
            hold = 1'b0;
        end
    endtask

    // Stimulus and end of run.
    initial begin
        logic [127:0] k;
        int n;
        int start;
        int filled;
        logic [HASH_W-1:0] h;

        // Directed keys: zero byte with a negative hash, the same magnitude from a
        // positive hash, zero hash, top byte, an absent key, and the most negative hash.
        push_key(128'd0, 1, CMD_INSERT, 1'b0);
        known_key.push_back(128'd0);
        known_len.push_back(1);
        push_key(128'd62, 1, CMD_LOOKUP, 1'b0);
        push_key(128'd62, 1, CMD_INSERT, 1'b0);
        push_key(128'd31, 1, CMD_INSERT, 1'b0);
        push_key(128'd31, 1, CMD_LOOKUP, 1'b0);
        push_key(128'd255, 1, CMD_INSERT, 1'b0);
        push_key(128'd255, 1, CMD_LOOKUP, 1'b0);
        push_key(128'd0, 2, CMD_LOOKUP, 1'b0);
        n = base31_key(64'h8000_0000_0000_0000, k);
        push_key(k, n, CMD_INSERT, 1'b0);
        known_key.push_back(k);
        known_len.push_back(n);

        // The largest positive hash has the same magnitude as the most negative one.
        n = base31_key(64'h7FFF_FFFF_FFFF_FFFF, k);
        push_key(k, n, CMD_LOOKUP, 1'b1);
        known_key.push_back(k);
        known_len.push_back(n);
        mixed_keys(500, 1'b0);

        // Fill one bank past its slot count with distinct two-byte keys; a second
        // byte of 31..61 is one base-31 digit, so every key has its own hash.
        start = $urandom_range(0, 223);
        filled = 0;
        for (int j = 0; j < 224 && filled < HBKS_SLOTS_PER_BANK + 8; j++) begin
            for (int b1 = 31; b1 <= 61 && filled < HBKS_SLOTS_PER_BANK + 8; b1++) begin
                k = '0;
                k[7:0]  = BYTE_W'(32 + (start + j) % 224);
                k[15:8] = BYTE_W'(b1);
                h = fold_byte(fold_byte('0, k[7:0]), k[15:8]);
                if (hash_magnitude(h) % MAG_W'(HBKS_BANK_COUNT) == MAG_W'(FULL_BANK)) begin
                    push_key(k, 2, CMD_INSERT, filled == 0);
                    if (filled % 4 == 0) begin
                        known_key.push_back(k);
                        known_len.push_back(2);
                    end
                    filled++;
                    if ($urandom_range(0, 9) == 0)
                        resend_known($urandom_range(0, 1) ? CMD_LOOKUP : CMD_INSERT, 1'b0);
                end
            end
        end
        mixed_keys(TOTAL_ITEMS, 1'b1);

        // Wait for every transfer, then every result, then a quiet stretch.
        while (byte_q.size() != 0 || in_valid) @(negedge clk);
        while (answer_q.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Input driver: predicts each accepted transfer and loads the next byte.
    always @(posedge clk) begin : drive
        bit calm_in;
        if (!rst_n) begin
            in_valid  <= 1'b0;
            acc_hash  = '0;
            len_count = '0;
            foreach (slot_hash[b, s]) begin
                slot_hash[b][s] = '0;
                slot_len[b][s]  = '0;
            end
        end else begin
            calm_in = (sent_items >= 700 && sent_items < 1000);
            if (in_valid && !in_stall) begin
                track_key_byte(in_data);
                sent_items++;
            end
            if (!in_valid || !in_stall) begin
                if (byte_q.size() != 0 && !(byte_q[0].hold && answer_q.size() != 0) &&
                    (calm_in || $urandom_range(0, 99) >= 16)) begin
                    in_valid <= 1'b1;
                    in_data  <= byte_q[0].item;
                    byte_q.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: compares each accepted result with the oldest expectation.
    always @(posedge clk) begin : watch
        t_out_item want;
        bit calm_out;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            calm_out = (results_seen >= 150 && results_seen < 260);
            if (out_valid && !out_stall) begin
                if (answer_q.size() == 0) begin
                    flag_mismatch("unexpected result", 64'(out_data.key_hash), '0);
                end else begin
                    want = answer_q.pop_front();
                    if (out_data.key_hash !== want.key_hash)
                        flag_mismatch("key_hash", 64'(out_data.key_hash), 64'(want.key_hash));
                    if (out_data.bank_index !== want.bank_index)
                        flag_mismatch("bank_index", 64'(out_data.bank_index),
                                      64'(want.bank_index));
                    if (out_data.present !== want.present)
                        flag_mismatch("present", 64'(out_data.present), 64'(want.present));
                    if (out_data.newly_stored !== want.newly_stored)
                        flag_mismatch("newly_stored", 64'(out_data.newly_stored),
                                      64'(want.newly_stored));
                    if (out_data.bank_full !== want.bank_full)
                        flag_mismatch("bank_full", 64'(out_data.bank_full),
                                      64'(want.bank_full));
                end
                results_seen++;
            end
            out_stall <= !calm_out && ($urandom_range(0, 99) < 16);
        end
    end

    // Run limit.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

// File: sim.f
hw/rtl/hbks_pkg.sv
hw/rtl/hbks_ram.sv
hw/rtl/hbks_ctrl.sv
hw/rtl/hbks_datapath.sv
hw/rtl/hash_banked_key_set.sv
verif/tb_top.sv
